>>> rtl/core/psu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants for the PNG scanline unfilter
// Holds configuration register indexes, opcodes, filter and mode codes and the Paeth predictor.
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int unsigned MaxWidthDefault     = 4096;
	localparam int unsigned PaletteDepthDefault = 256;

	typedef enum logic [2:0] {
		CFG_WIDTH   = 3'd0,
		CFG_HEIGHT  = 3'd1,
		CFG_MODE    = 3'd2,
		CFG_PAL_CNT = 3'd3,
		CFG_ALP_CNT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_PAL   = 2'd1,
		OP_START = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	typedef enum logic [2:0] {
		MODE_GRAY  = 3'd0,
		MODE_GA    = 3'd1,
		MODE_RGB   = 3'd2,
		MODE_RGBA  = 3'd3,
		MODE_PAL   = 3'd4
	} mode_t;

	// Paeth predictor on 8-bit samples
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] p, pa, pb, pc;
		p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		pa = p - $signed({3'b000, a});
		pb = p - $signed({3'b000, b});
		pc = p - $signed({3'b000, c});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/psu_palette.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psu_palette: palette lookup
// Palette memory with registered read; applies entry and alpha limits.
// ----------------------------------------------------------------------------
module psu_palette #(
	parameter int unsigned PALETTE_DEPTH = psu_pkg::PaletteDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire logic [7:0]  wr_index,
	input  wire logic [31:0] wr_data,
	input  wire logic        rd_en,
	input  wire logic [7:0]  rd_index,
	input  wire logic [8:0]  pal_count,
	input  wire logic [8:0]  alp_count,
	output logic      [31:0] rd_rgba
);
	localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [31:0] mem [PALETTE_DEPTH];
	logic [31:0] entry_q;
	logic        col_ok_q, alp_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en && ({1'b0, wr_index} < 9'(PALETTE_DEPTH)))
			mem[wr_index[IdxW-1:0]] <= wr_data;
		if (rd_en) begin
			entry_q  <= mem[rd_index[IdxW-1:0]];
			col_ok_q <= ({1'b0, rd_index} < pal_count) && ({1'b0, rd_index} < 9'(PALETTE_DEPTH));
			alp_ok_q <= ({1'b0, rd_index} < alp_count) && ({1'b0, rd_index} < 9'(PALETTE_DEPTH));
		end
	end

	assign rd_rgba[23:0]  = col_ok_q ? entry_q[23:0] : 24'd0;
	assign rd_rgba[31:24] = alp_ok_q ? entry_q[31:24] : 8'hFF;
endmodule
`default_nettype wire

>>> rtl/core/png_scanline_unfilter_rgba_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgba_top: PNG row unfilter with RGBA conversion
// Rebuilds 8-bit PNG samples against a prior-row line store, emits pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (opcode, data_byte, pal_*) arrive on in_valid/in_ready;
//   opcode 0 carries filter and sample bytes, 1 writes a palette entry and
//   2 starts a new image. Pixels leave on out_valid/out_ready.
//   One request is taken per cycle while in_ready is high. The request that
//   completes a pixel passes stage one, which reads the line store, then
//   stage two, which rebuilds the sample, writes it back and reads the
//   palette, and the palette lookup lands the pixel in a four-entry result queue.
//   A bad filter byte gives one error result, then bytes are dropped until
//   the next start request.
//   After reset, and after every start request, the line store is swept
//   clear, one entry per cycle over all 4*MAX_WIDTH entries (16384 by default);
//   input is held off during the sweep, configuration writes are taken.
//   When the receiver stalls, the result queue holds results; input ready
//   drops once the queue plus the results still in the pipeline reach four.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_rgba_top #(
	parameter int unsigned MAX_WIDTH     = psu_pkg::MaxWidthDefault,
	parameter int unsigned PALETTE_DEPTH = psu_pkg::PaletteDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  pal_index,
	input  wire logic [7:0]  pal_red,
	input  wire logic [7:0]  pal_green,
	input  wire logic [7:0]  pal_blue,
	input  wire logic [7:0]  pal_alpha,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  red,
	output logic      [7:0]  green,
	output logic      [7:0]  blue,
	output logic      [7:0]  alpha,
	output logic             row_end,
	output logic             image_end,
	output logic             error
);
	localparam int unsigned Depth  = MAX_WIDTH * 4;
	localparam int unsigned AW     = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW     = $clog2(Depth + 1);
	localparam int unsigned QDepth = 4;

	typedef struct packed {
		logic [7:0] r, g, b, a;
		logic       rend, iend, err;
	} res_t;

	// configuration
	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  mode_q;
	logic [8:0]  pal_cnt_q, alp_cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 13'd1;
			height_q  <= 16'd1;
			mode_q    <= 3'd0;
			pal_cnt_q <= 9'd0;
			alp_cnt_q <= 9'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psu_pkg::CFG_WIDTH:   width_q   <= cfg_data[12:0];
				psu_pkg::CFG_HEIGHT:  height_q  <= cfg_data;
				psu_pkg::CFG_MODE:    mode_q    <= cfg_data[2:0];
				psu_pkg::CFG_PAL_CNT: pal_cnt_q <= cfg_data[8:0];
				psu_pkg::CFG_ALP_CNT: alp_cnt_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic [2:0] chans;
	always_comb begin
		case (mode_q)
			psu_pkg::MODE_GA:   chans = 3'd2;
			psu_pkg::MODE_RGB:  chans = 3'd3;
			psu_pkg::MODE_RGBA: chans = 3'd4;
			default:            chans = 3'd1;
		endcase
	end

	logic [CW-1:0] eff_w, stride;
	always_comb begin
		if (width_q == 13'd0)                    eff_w = CW'(1);
		else if (32'(width_q) > MAX_WIDTH)       eff_w = CW'(MAX_WIDTH);
		else                                     eff_w = CW'(width_q);
	end
	// chans is at most four: shift-and-add, no multiplier
	always_comb begin
		case (chans)
			3'd2:    stride = CW'(eff_w << 1);
			3'd3:    stride = CW'((eff_w << 1) + eff_w);
			3'd4:    stride = CW'(eff_w << 2);
			default: stride = eff_w;
		endcase
	end

	// clearing sweep
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// result queue
	res_t       res_fifo_q [QDepth];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       s1_v, s2_emit, v_s3;

	// stage 1 control state
	logic          await_q, halt_q;
	logic [2:0]    filt_q;
	logic [CW-1:0] col_q;
	logic [1:0]    m3_q;
	logic [15:0]   row_q;

	// queue entries plus results still in the pipeline never exceed the queue
	logic [2:0] busy;
	assign busy     = cnt_q + 3'(s1_v) + 3'(v_s3);
	assign in_ready = !clr_q && (busy < 3'(QDepth));

	logic acc;
	assign acc = in_valid && in_ready;

	logic is_byte, is_start;
	assign is_byte  = acc && (opcode == psu_pkg::OP_BYTE) && !halt_q;
	assign is_start = acc && (opcode == psu_pkg::OP_START);

	logic samp, badf;
	assign samp = is_byte && !await_q;
	assign badf = is_byte && await_q && (data_byte > 8'd4);

	logic [CW-1:0] col_c, col_n;
	assign col_c = (col_q >= CW'(Depth)) ? CW'(Depth - 1) : col_q;
	assign col_n = col_c + CW'(1);

	logic rend_c;
	assign rend_c = col_n >= stride;
	logic [15:0] last_row;
	assign last_row = (height_q == 16'd0) ? 16'd0 : height_q - 16'd1;

	// channel within the pixel: column modulo the channel count
	logic [1:0] k_c;
	always_comb begin
		case (chans)
			3'd2:    k_c = {1'b0, col_c[0]};
			3'd3:    k_c = m3_q;
			3'd4:    k_c = col_c[1:0];
			default: k_c = 2'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b1;
			halt_q  <= 1'b0;
			filt_q  <= 3'd0;
			col_q   <= '0;
			m3_q    <= 2'd0;
			row_q   <= 16'd0;
		end else if (is_start) begin
			await_q <= 1'b1;
			halt_q  <= 1'b0;
			filt_q  <= 3'd0;
			col_q   <= '0;
			m3_q    <= 2'd0;
			row_q   <= 16'd0;
		end else if (badf) begin
			halt_q <= 1'b1;
		end else if (is_byte && await_q) begin
			filt_q  <= data_byte[2:0];
			await_q <= 1'b0;
			col_q   <= '0;
			m3_q    <= 2'd0;
		end else if (samp) begin
			if (rend_c) begin
				await_q <= 1'b1;
				col_q   <= '0;
				m3_q    <= 2'd0;
				if (row_q != 16'hFFFF) row_q <= row_q + 16'd1;
			end else begin
				col_q <= col_n;
				m3_q  <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
			end
		end
	end

	// stage 1 -> 2 pipeline
	logic          v_s1, err_s1, emit_s1, rend_s1, iend_s1, rst_s1;
	logic [7:0]    byte_s1;
	logic [2:0]    filt_s1;
	logic [1:0]    k_s1;
	logic [AW-1:0] addr_s1;

	assign s1_v = v_s1 && (emit_s1 || err_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			err_s1 <= 1'b0;
			rst_s1 <= 1'b0;
		end else begin
			v_s1   <= samp || badf;
			err_s1 <= badf;
			// row start (or new image) zeroes the neighbour registers
			rst_s1 <= is_start || (is_byte && await_q && !badf);
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= data_byte;
		filt_s1 <= filt_q;
		k_s1    <= k_c;
		addr_s1 <= col_c[AW-1:0];
		emit_s1 <= ({1'b0, k_c} == chans - 3'd1);
		rend_s1 <= rend_c;
		iend_s1 <= rend_c && (row_q == last_row);
	end

	// line store
	logic [7:0]    store [Depth];
	logic [7:0]    b_rd_s1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_val, val_s2;
	logic          fwd_s1;
	logic [7:0]    fwd_val_s1;

	always_ff @(posedge clk) begin
		if (wr_en) store[wr_addr] <= wr_val;
		b_rd_s1 <= store[col_c[AW-1:0]];
	end

	// a write in flight to the same address as the read is forwarded
	always_ff @(posedge clk) begin
		fwd_s1     <= v_s1 && !err_s1 && (addr_s1 == col_c[AW-1:0]);
		fwd_val_s1 <= val_s2;
	end

	logic [7:0] b_s2;
	assign b_s2 = fwd_s1 ? fwd_val_s1 : b_rd_s1;

	// stage 2: rebuild
	logic [31:0] left_q, ul_q;
	logic [23:0] gath_q;
	logic [7:0]  a_s2, c_s2, pred;
	assign a_s2 = left_q[8*k_s1 +: 8];
	assign c_s2 = ul_q[8*k_s1 +: 8];

	always_comb begin
		case (filt_s1)
			psu_pkg::FLT_SUB:   pred = a_s2;
			psu_pkg::FLT_UP:    pred = b_s2;
			psu_pkg::FLT_AVG:   pred = 8'((9'(a_s2) + 9'(b_s2)) >> 1);
			psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(a_s2, b_s2, c_s2);
			default:            pred = 8'd0;
		endcase
	end
	assign val_s2 = byte_s1 + pred;

	logic samp_s2;
	assign samp_s2 = v_s1 && !err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			ul_q   <= '0;
			gath_q <= '0;
		end else if (rst_s1) begin
			left_q <= '0;
			ul_q   <= '0;
			gath_q <= '0;
		end else if (samp_s2) begin
			left_q[8*k_s1 +: 8] <= val_s2;
			ul_q[8*k_s1 +: 8]   <= b_s2;
			if (k_s1 != 2'd3) gath_q[8*k_s1 +: 8] <= val_s2;
		end
	end

	assign wr_en   = clr_q || samp_s2;
	assign wr_addr = clr_q ? clr_addr_q : addr_s1;
	assign wr_val  = clr_q ? 8'd0 : val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (is_start) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(Depth - 1)) clr_q <= 1'b0;
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// palette: read with stage 2 value is too late, so look up one stage on
	logic [31:0] pal_rgba;
	logic        pal_emit_s3;
	res_t        base_s3;

	psu_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_pal (
		.clk       (clk),
		.wr_en     (acc && (opcode == psu_pkg::OP_PAL)),
		.wr_index  (pal_index),
		.wr_data   ({pal_alpha, pal_blue, pal_green, pal_red}),
		.rd_en     (1'b1),
		.rd_index  (val_s2),
		.pal_count (pal_cnt_q),
		.alp_count (alp_cnt_q),
		.rd_rgba   (pal_rgba)
	);

	res_t res_s2;
	always_comb begin
		res_s2      = '0;
		res_s2.rend = rend_s1;
		res_s2.iend = iend_s1;
		case (mode_q)
			psu_pkg::MODE_GA: begin
				res_s2.r = gath_q[7:0]; res_s2.g = gath_q[7:0];
				res_s2.b = gath_q[7:0]; res_s2.a = val_s2;
			end
			psu_pkg::MODE_RGB: begin
				res_s2.r = gath_q[7:0]; res_s2.g = gath_q[15:8];
				res_s2.b = val_s2;      res_s2.a = 8'hFF;
			end
			psu_pkg::MODE_RGBA: begin
				res_s2.r = gath_q[7:0];   res_s2.g = gath_q[15:8];
				res_s2.b = gath_q[23:16]; res_s2.a = val_s2;
			end
			default: begin
				res_s2.r = val_s2; res_s2.g = val_s2;
				res_s2.b = val_s2; res_s2.a = 8'hFF;
			end
		endcase
		if (err_s1) res_s2 = '{err: 1'b1, default: '0};
	end

	assign s2_emit = v_s1 && (emit_s1 || err_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= s2_emit;
	end
	always_ff @(posedge clk) begin
		base_s3     <= res_s2;
		pal_emit_s3 <= (mode_q == psu_pkg::MODE_PAL) && !err_s1;
	end

	res_t res_s3;
	always_comb begin
		res_s3 = base_s3;
		if (pal_emit_s3) begin
			res_s3.r = pal_rgba[7:0];
			res_s3.g = pal_rgba[15:8];
			res_s3.b = pal_rgba[23:16];
			res_s3.a = pal_rgba[31:24];
		end
	end

	logic q_push, q_pop;
	assign q_push = v_s3;
	assign q_pop  = (cnt_q != 3'd0) && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (q_push) wp_q <= wp_q + 2'd1;
			if (q_pop)  rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(q_push) - 3'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) res_fifo_q[wp_q] <= res_s3;
	end

	assign out_valid = (cnt_q != 3'd0);
	assign red       = res_fifo_q[rp_q].r;
	assign green     = res_fifo_q[rp_q].g;
	assign blue      = res_fifo_q[rp_q].b;
	assign alpha     = res_fifo_q[rp_q].a;
	assign row_end   = res_fifo_q[rp_q].rend;
	assign image_end = res_fifo_q[rp_q].iend;
	assign error     = res_fifo_q[rp_q].err;
endmodule
`default_nettype wire

>>> rtl/core/psu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psu_checker: port-level checks for the scanline unfilter
// Watches the top level's handshakes and result fields.
// ----------------------------------------------------------------------------
module psu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic [7:0] alpha,
	input wire logic       row_end,
	input wire logic       image_end,
	input wire logic       error
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(error))
		else $error("result changed while stalled");

	// an error result carries no pixel
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> red == 8'd0 && alpha == 8'd0 && !row_end)
		else $error("error result has pixel data");

	// image end only on a row end
	a_iend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

	// nothing shown straight out of reset
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid && !in_ready)
		else $error("activity right after reset");
	logic unused;
	assign unused = ^{green, blue};
endmodule

bind png_scanline_unfilter_rgba_top psu_checker u_psu_checker (.*);
`default_nettype wire
